/* sv/lpc_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page cache package
// Shared constants and types for the LRU page cache hit counter.
// ----------------------------------------------------------------------------
`default_nettype none
package lpc_pkg;
    localparam int MAX_SLOTS = 1024;
    localparam int KEY_BITS  = 32;
    localparam int IDX_BITS  = $clog2(MAX_SLOTS);
    localparam int OCC_BITS  = $clog2(MAX_SLOTS + 1);
    localparam int CFG_BITS  = 11;
    localparam int CNT_BITS  = 32;
    localparam int QDEPTH    = 2;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [IDX_BITS-1:0] t_idx;
    typedef logic [OCC_BITS-1:0] t_occ;
    typedef logic [CNT_BITS-1:0] t_cnt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_UPDATE,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic hit;
        logic evicted;
        t_key evicted_key;
        t_cnt hits_total;
        t_cnt accesses_total;
    } t_result;
endpackage
`default_nettype wire

/* sv/lru_page_cache_hit_counter.sv */
// ----------------------------------------------------------------------------
// LRU page cache hit counter
// Fully associative LRU cache of page keys with hit and access totals.
// ----------------------------------------------------------------------------
// Usage: page keys arrive on the slave stream (s_axis_*), one key per
// transaction, and each key yields exactly one result transaction on the
// master stream (m_axis_*). The number of slots in use is written through
// i_cfg_we / i_cfg_data while the block is idle; zero acts as one and values
// above 1024 act as 1024.
// An access to a non-empty cache scans the slot memories twice, once to find
// the key and the least recent page and once to age the ranks, at one slot
// per cycle through the registered memory read port. The engine takes the
// next key only after the result of the last one is in the output register.
// The front queue holds two keys; the source stalls only while it is full.
// Reset clears occupancy, the totals and the queue; the slot memories need no
// clearing because only occupied slots are ever used. When the receiver
// stalls, the result is held in the output register; the engine runs the next
// access and then waits with its result until the held one has been taken.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_page_cache_hit_counter (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [10:0]  i_cfg_data,     // slot limit
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [31:0]  s_axis_tdata,   // page_key
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // evicted_key[31:0], hits_total[63:32],
                                         // accesses_total[95:64]
    output logic [1:0]   m_axis_tuser    // hit[0], evicted[1]
);
    import lpc_pkg::*;

    logic [CFG_BITS-1:0] r_cfg;
    logic  q_valid, q_take;
    t_key  q_key;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg <= CFG_BITS'(MAX_SLOTS);
        else if (i_cfg_we) r_cfg <= i_cfg_data;
    end

    lpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_key(s_axis_tdata),
        .o_valid(q_valid), .i_take(q_take), .o_key(q_key));

    lpc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_slots(r_cfg),
        .i_valid(q_valid), .o_take(q_take), .i_key(q_key),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res));

    assign m_axis_tdata = {res.accesses_total, res.hits_total, res.evicted_key};
    assign m_axis_tuser = {res.evicted, res.hit};
endmodule
`default_nettype wire

/* sv/lpc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/lpc_front.sv */
// ----------------------------------------------------------------------------
// LRU page cache front end
// Accepts page keys into a short queue in front of the lookup engine.
// ----------------------------------------------------------------------------
`default_nettype none
module lpc_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  lpc_pkg::t_key i_key,
    output logic              o_valid,
    input  wire               i_take,
    output lpc_pkg::t_key     o_key
);
    import lpc_pkg::*;

    t_key r_q [QDEPTH];
    logic [$clog2(QDEPTH+1)-1:0] r_cnt;
    logic [$clog2(QDEPTH)-1:0]   r_rd;
    logic [$clog2(QDEPTH)-1:0]   r_wr;
    logic push, pop;

    assign o_ready = (r_cnt != QDEPTH[$clog2(QDEPTH+1)-1:0]);
    assign o_valid = (r_cnt != '0);
    assign o_key   = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
            r_wr  <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            if (push && !pop) r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
        if (push) r_q[r_wr] <= i_key;
    end
endmodule
`default_nettype wire

/* sv/lpc_back.sv */
// ----------------------------------------------------------------------------
// LRU page cache back end
// Scans the slot memories, updates recency ranks and produces results.
// ----------------------------------------------------------------------------
`default_nettype none
module lpc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [lpc_pkg::CFG_BITS-1:0] i_cfg_slots,
    input  wire                 i_valid,
    output logic                o_take,
    input  wire  lpc_pkg::t_key i_key,
    output logic                o_valid,
    input  wire                 i_ready,
    output lpc_pkg::t_result    o_res
);
    import lpc_pkg::*;

    t_state r_state, n_state;
    t_key   r_key;
    t_occ   r_occ, r_lim;
    t_idx   r_idx;
    logic   r_rvalid;
    t_idx   r_ridx;
    logic   r_hit, r_old_found;
    t_idx   r_hit_idx, r_old_idx;
    logic [IDX_BITS-1:0] r_bound_rank;
    t_key   r_old_key;
    t_cnt   r_hits, r_acc;
    t_result r_res;
    logic   r_ovalid;
    logic   r_evict;

    // RAM ports
    logic   key_we, rank_we;
    t_idx   key_waddr, rank_waddr, raddr;
    t_key   key_wdata, key_rdata;
    t_idx   rank_wdata, rank_rdata;
    t_occ   bound;

    lpc_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_SLOTS)) u_keys (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(key_wdata),
        .i_raddr(raddr), .o_rdata(key_rdata));
    lpc_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_SLOTS)) u_rank (
        .i_clk(i_clk), .i_we(rank_we), .i_waddr(rank_waddr), .i_wdata(rank_wdata),
        .i_raddr(raddr), .o_rdata(rank_rdata));

    t_occ cfg_lim;
    always_comb begin
        if (i_cfg_slots == '0) cfg_lim = OCC_BITS'(1);
        else if ({1'b0, i_cfg_slots} > (CFG_BITS+1)'(MAX_SLOTS)) cfg_lim = OCC_BITS'(MAX_SLOTS);
        else cfg_lim = OCC_BITS'(i_cfg_slots);
    end

    // The read data in a cycle belongs to slot r_ridx; r_idx runs one slot
    // ahead and stops at the last occupied slot.
    logic last_idx;
    logic idx_more;
    assign last_idx = ({1'b0, r_ridx} + (IDX_BITS+1)'(1)) >= (IDX_BITS+1)'(r_occ);
    assign idx_more = ({1'b0, r_idx} + (IDX_BITS+1)'(1)) < (IDX_BITS+1)'(r_occ);
    assign raddr    = (r_state == ST_IDLE) ? '0 : r_idx;
    assign o_take   = (r_state == ST_IDLE);
    assign o_valid  = r_ovalid;
    assign o_res    = r_res;

    // Age bound: hit -> rank of hit slot, evict -> occ-1, insert -> occ.
    always_comb begin
        if (r_hit) bound = OCC_BITS'(r_bound_rank);
        else if (r_evict) bound = r_occ - 1'b1;
        else bound = r_occ;
    end

    always_comb begin
        n_state    = r_state;
        key_we     = 1'b0;
        rank_we    = 1'b0;
        key_waddr  = r_idx;
        rank_waddr = r_ridx;
        key_wdata  = r_key;
        rank_wdata = rank_rdata + 1'b1;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = (r_occ == '0) ? ST_DECIDE : ST_SEARCH;
            ST_SEARCH: if (r_rvalid && last_idx) n_state = ST_DECIDE;
            ST_DECIDE: n_state = (r_occ == '0) ? ST_WRITE : ST_UPDATE;
            ST_UPDATE: begin
                if (r_rvalid && OCC_BITS'(rank_rdata) < bound) rank_we = 1'b1;
                if (r_rvalid && last_idx) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                rank_we    = 1'b1;
                rank_wdata = '0;
                key_we     = !r_hit;
                if (r_hit) rank_waddr = r_hit_idx;
                else if (r_evict) rank_waddr = r_old_idx;
                else rank_waddr = IDX_BITS'(r_occ);
                key_waddr  = rank_waddr;
                n_state    = ST_OUT;
            end
            ST_OUT: if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_occ    <= '0;
            r_hits   <= '0;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            r_ridx   <= raddr;
            case (r_state)
                ST_IDLE: begin
                    r_key       <= i_key;
                    r_lim       <= cfg_lim;
                    r_idx       <= (r_occ > OCC_BITS'(1)) ? IDX_BITS'(1) : '0;
                    r_rvalid    <= i_valid;
                    r_hit       <= 1'b0;
                    r_old_found <= 1'b0;
                    r_old_idx   <= '0;
                end
                ST_SEARCH: begin
                    if (r_rvalid) begin
                        if (!r_hit && key_rdata == r_key) begin
                            r_hit        <= 1'b1;
                            r_hit_idx    <= r_ridx;
                            r_bound_rank <= rank_rdata;
                        end
                        if (!r_old_found && OCC_BITS'(rank_rdata) == r_occ - 1'b1) begin
                            r_old_found <= 1'b1;
                            r_old_idx   <= r_ridx;
                            r_old_key   <= key_rdata;
                        end
                    end
                    if (r_rvalid && last_idx) begin
                        r_idx    <= '0;
                        r_rvalid <= 1'b0;
                    end else begin
                        if (idx_more) r_idx <= r_idx + 1'b1;
                        r_rvalid <= 1'b1;
                    end
                end
                ST_DECIDE: begin
                    r_evict  <= !r_hit && (r_occ >= r_lim) && (r_occ != '0);
                    r_rvalid <= 1'b1;
                    r_idx    <= (r_occ > OCC_BITS'(1)) ? IDX_BITS'(1) : '0;
                end
                ST_UPDATE: begin
                    if (r_rvalid && last_idx) r_rvalid <= 1'b0;
                    else if (idx_more) r_idx <= r_idx + 1'b1;
                end
                ST_WRITE: begin
                    if (!r_hit && !r_evict && r_occ != t_occ'(MAX_SLOTS))
                        r_occ <= r_occ + 1'b1;
                    if (r_hit && r_hits != '1) r_hits <= r_hits + 1'b1;
                    if (r_acc != '1) r_acc <= r_acc + 1'b1;
                end
                ST_OUT: begin
                    // The held result is replaced only once it has been taken.
                    if (!r_ovalid || i_ready) begin
                        r_res.hit            <= r_hit;
                        r_res.evicted        <= r_evict;
                        r_res.evicted_key    <= r_evict ? r_old_key : '0;
                        r_res.hits_total     <= r_hits;
                        r_res.accesses_total <= r_acc;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
